### hdl/otmt_pkg.sv
// Shared types and constants for the OpenTherm Manchester transceiver.
package otmt_pkg;

    // Width of the listen timeout counter
    localparam int unsigned TIMEOUT_BITS = 16;

    // Bit counter value that marks the stop bit position
    localparam logic [5:0] LAST_POS = 6'd33;

    // Reset value of the listen timeout register
    localparam logic [15:0] TIMEOUT_RESET = 16'd4000;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_LISTEN = 2'd1,
        CMD_SEND   = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        M_IDLE     = 3'd0,
        M_LISTEN   = 3'd1,
        M_READ     = 3'd2,
        M_RECEIVED = 3'd3,
        M_WRITE    = 3'd4,
        M_SENT     = 3'd5,
        M_PROTO    = 3'd6,
        M_TIMEOUT  = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        E_NONE      = 3'd0,
        E_NO_MID    = 3'd1,
        E_NO_CHANGE = 3'd2,
        E_PARITY    = 3'd3,
        E_STOP      = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        RATE_STOPPED  = 2'd0,
        RATE_FIVE_BIT = 2'd1,
        RATE_TWO_BIT  = 2'd2
    } rate_t;

endpackage

### hdl/otmt_if.sv
// Valid/ready channel interfaces for commands, results and configuration.
interface otmt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic        line_level;
    logic [31:0] send_data;

    modport source (output valid, output command, output line_level, output send_data,
                    input ready);
    modport sink (input valid, input command, input line_level, input send_data,
                  output ready);
endinterface

interface otmt_rsp_if;
    logic        valid;
    logic        ready;
    logic        out_level;
    logic [2:0]  status;
    logic [2:0]  error_code;
    logic [31:0] received_data;
    logic [1:0]  tick_rate;

    modport source (output valid, output out_level, output status, output error_code,
                    output received_data, output tick_rate, input ready);
    modport sink (input valid, input out_level, input status, input error_code,
                  input received_data, input tick_rate, output ready);
endinterface

interface otmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/opentherm_manchester_transceiver_core.sv
// OpenTherm Manchester transceiver core: every command or tick transfer yields one result
// transfer that shows line drive, status, error, frame and requested tick rate after the
// update. One item is taken per clock and its result is offered from the following cycle;
// the state registers double as the result register, so a new item is taken in the same
// cycle the pending result is transferred, and only a stalled result holds off the command
// channel. The timeout register is written through the configuration channel, which is
// always ready.
module opentherm_manchester_transceiver_core (
    input  logic       clk,
    input  logic       rst_n,
    otmt_req_if.sink   req,
    otmt_rsp_if.source rsp,
    otmt_cfg_if.sink   cfg
);
    import otmt_pkg::*;

    logic [15:0]             timeout_ticks_reg;
    mode_t                   mode_reg, mode_next;
    err_t                    err_reg, err_next;
    logic [31:0]             frame_reg, frame_next;
    logic [5:0]              bit_idx_reg, bit_idx_next;
    logic                    half_reg, half_next;
    logic [8:0]              hist_reg, hist_next;
    logic [TIMEOUT_BITS-1:0] tmo_left_reg, tmo_left_next;
    logic                    drive_reg, drive_next;
    logic                    rsp_valid_reg;

    logic  accept;
    cmd_t  cmd;
    logic  last_smp;
    logic  long_run;
    logic  tx_bit;

    // Take a new item whenever the result slot is free or being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cmd       = cmd_t'(req.command);
    assign cfg.ready = 1'b1;

    assign last_smp = hist_reg[0];
    assign long_run = |hist_reg[8:4];

    // Select the transmit bit: start, stop and out-of-range positions send one
    always_comb
    begin
        if (bit_idx_reg == LAST_POS || bit_idx_reg == 6'd0 || bit_idx_reg > 6'd32)
        begin
            tx_bit = 1'b1;
        end
        else
        begin
            tx_bit = frame_reg[5'(bit_idx_reg - 6'd1)];
        end
    end

    // Next state for one command or tick
    always_comb
    begin
        mode_next     = mode_reg;
        err_next      = err_reg;
        frame_next    = frame_reg;
        bit_idx_next  = bit_idx_reg;
        half_next     = half_reg;
        hist_next     = hist_reg;
        tmo_left_next = tmo_left_reg;
        drive_next    = drive_reg;
        unique case (cmd)
            CMD_LISTEN:
            begin
                tmo_left_next = TIMEOUT_BITS'(timeout_ticks_reg);
                bit_idx_next  = 6'd0;
                err_next      = E_NONE;
                mode_next     = M_LISTEN;
            end
            CMD_SEND:
            begin
                frame_next   = req.send_data;
                half_next    = 1'b1;
                bit_idx_next = LAST_POS;
                err_next     = E_NONE;
                mode_next    = M_WRITE;
            end
            CMD_STOP:
            begin
                mode_next = M_IDLE;
            end
            CMD_TICK:
            begin
                unique case (mode_reg)
                    M_LISTEN:
                    begin
                        if (tmo_left_reg == '0)
                        begin
                            mode_next = M_TIMEOUT;
                        end
                        else
                        begin
                            if (req.line_level)
                            begin
                                frame_next   = '0;
                                bit_idx_next = 6'd0;
                                mode_next    = M_READ;
                                hist_next    = 9'd1;
                                half_next    = 1'b1;
                            end
                            tmo_left_next = tmo_left_reg - 1'b1;
                        end
                    end
                    M_READ:
                    begin
                        if (req.line_level != last_smp)
                        begin
                            if (half_reg && long_run)
                            begin
                                mode_next = M_PROTO;
                                err_next  = E_NO_MID;
                            end
                            else if (half_reg || long_run)
                            begin
                                // Mid-bit transition: a data point
                                if (bit_idx_reg == LAST_POS)
                                begin
                                    if (!last_smp)
                                    begin
                                        mode_next = M_PROTO;
                                        err_next  = E_STOP;
                                    end
                                    else if (!(^frame_reg))
                                    begin
                                        mode_next = M_RECEIVED;
                                    end
                                    else
                                    begin
                                        mode_next = M_PROTO;
                                        err_next  = E_PARITY;
                                    end
                                end
                                else
                                begin
                                    frame_next   = {frame_reg[30:0], last_smp};
                                    bit_idx_next = bit_idx_reg + 6'd1;
                                    half_next    = 1'b0;
                                    hist_next    = {7'd0, 1'b1, req.line_level};
                                end
                            end
                            else
                            begin
                                // Boundary transition
                                half_next = 1'b1;
                                hist_next = {7'd0, 1'b1, req.line_level};
                            end
                        end
                        else if (hist_reg[8])
                        begin
                            mode_next = M_PROTO;
                            err_next  = E_NO_CHANGE;
                        end
                        else
                        begin
                            hist_next = {hist_reg[7:0], req.line_level};
                        end
                    end
                    M_WRITE:
                    begin
                        if (half_reg)
                        begin
                            drive_next = ~tx_bit;
                            half_next  = 1'b0;
                        end
                        else
                        begin
                            drive_next = tx_bit;
                            if (bit_idx_reg == 6'd0)
                            begin
                                mode_next = M_SENT;
                            end
                            bit_idx_next = bit_idx_reg - 6'd1;
                            half_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Drive the result fields from the state
    always_comb
    begin
        rsp.valid         = rsp_valid_reg;
        rsp.out_level     = drive_reg;
        rsp.status        = mode_reg;
        rsp.error_code    = err_reg;
        rsp.received_data = frame_reg;
        priority if (mode_reg == M_LISTEN || mode_reg == M_READ)
        begin
            rsp.tick_rate = RATE_FIVE_BIT;
        end
        else if (mode_reg == M_WRITE)
        begin
            rsp.tick_rate = RATE_TWO_BIT;
        end
        else
        begin
            rsp.tick_rate = RATE_STOPPED;
        end
    end

    // Advance the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            err_reg      <= E_NONE;
            frame_reg    <= '0;
            bit_idx_reg  <= '0;
            half_reg     <= 1'b1;
            hist_reg     <= 9'd1;
            tmo_left_reg <= '0;
            drive_reg    <= 1'b1;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            err_reg      <= err_next;
            frame_reg    <= frame_next;
            bit_idx_reg  <= bit_idx_next;
            half_reg     <= half_next;
            hist_reg     <= hist_next;
            tmo_left_reg <= tmo_left_next;
            drive_reg    <= drive_next;
        end
    end

    // Hold the result until transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Load the listen timeout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            timeout_ticks_reg <= cfg.data;
        end
    end

`ifndef SYNTHESIS
    a_send_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_SEND) |=> (mode_reg == M_WRITE && bit_idx_reg == LAST_POS))
        else $error("send transfer did not arm the transmitter");

    a_proto_has_err: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_PROTO) |-> (err_reg != E_NONE))
        else $error("protocol error status without an error code");

    a_read_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_READ) |-> (bit_idx_reg <= LAST_POS))
        else $error("receive bit counter past the stop bit");

    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(mode_reg) && $stable(frame_reg) && $stable(drive_reg)))
        else $error("state changed without an accepted item");
`endif

endmodule
